### src/plist_pkg.sv
// Shared types and codes for the positional list engine.
// Depends on nothing; every other file in src imports it.
`timescale 1ns / 1ps

package plist_pkg;

    // Request opcodes
    typedef enum logic [2:0] {
        OP_INS_AT  = 3'd0,
        OP_APPEND  = 3'd1,
        OP_REM_AT  = 3'd2,
        OP_REM_VAL = 3'd3,
        OP_READ_AT = 3'd4,
        OP_COUNT   = 3'd5
    } t_opcode;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Fixed port widths
    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned HPORT_W  = 32;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch request and compare results
        logic execute;   // apply the request and load the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_valid; // result register holds an untaken beat
    } t_dp_sts;

endpackage

### src/plist_ctrl.sv
// Request sequencer for the positional list engine: idle / execute.
// Depends on plist_pkg.
`timescale 1ns / 1ps

module plist_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  plist_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output plist_pkg::t_dp_cmd o_cmd
);
    import plist_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_slot_free;

    assign w_slot_free = !i_sts.out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.execute = w_slot_free;
            end
            default: ;
        endcase
    end

endmodule

### src/plist_dp.sv
// Datapath of the positional list engine: entry registers, count, capacity
// register, request latch, parallel compare and result register. Uses plist_pkg.
`timescale 1ns / 1ps

module plist_dp #(
    parameter int unsigned DEPTH       = 16,
    parameter int unsigned HANDLE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  plist_pkg::t_dp_cmd                  i_cmd,
    output plist_pkg::t_dp_sts                  o_sts,
    input  logic                                i_cfg_we,
    input  logic [plist_pkg::CAP_W-1:0]         i_cfg_data,
    input  logic [plist_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [plist_pkg::POS_W-1:0]         i_position,
    input  logic [plist_pkg::HPORT_W-1:0]       i_handle_in,
    input  logic                                i_out_ready,
    output logic [plist_pkg::HPORT_W-1:0]       o_handle_out,
    output logic [plist_pkg::COUNT_W-1:0]       o_entry_count,
    output logic [plist_pkg::STATUS_W-1:0]      o_status
);
    import plist_pkg::*;

    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned IW   = $clog2(DEPTH);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

    // Storage and control state
    logic [HANDLE_BITS-1:0] r_entry [DEPTH];
    logic [HANDLE_BITS-1:0] n_entry [DEPTH];
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [CAP_W-1:0]       r_cap;

    // Latched request
    t_opcode                r_op;
    logic [POS_W-1:0]       r_pos;
    logic [HANDLE_BITS-1:0] r_hin;
    logic [DEPTH-1:0]       r_match;

    // Result register
    logic                   r_out_valid;
    logic [HPORT_W-1:0]     r_hout;
    logic [COUNT_W-1:0]     r_cnt_out;
    logic [STATUS_W-1:0]    r_status;

    logic [HANDLE_BITS-1:0] w_hin;
    logic [DEPTH-1:0]       w_match;
    logic [CMPW-1:0]        w_cnt_x;
    logic [CMPW-1:0]        w_pos_x;
    logic [CMPW-1:0]        w_cap_x;
    logic [CMPW-1:0]        w_dep_x;
    logic [CMPW-1:0]        w_cap_eff;
    logic [CMPW-1:0]        w_p;
    logic                   w_full;
    logic                   w_in_range;
    logic [IW-1:0]          w_idx;
    logic [HANDLE_BITS-1:0] w_rd;
    logic [DEPTH-1:0]       w_ge_val;
    logic                   w_do_ins;
    logic                   w_do_rem;
    logic                   w_use_val;
    logic [HPORT_W-1:0]     n_hout;
    logic [STATUS_W-1:0]    n_status;

    assign w_hin = HANDLE_BITS'(i_handle_in);

    // Compare the incoming handle against every live entry
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_match[i] = (r_entry[i] == w_hin) && (CW'(i) < r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_opcode'(i_opcode);
            r_pos   <= i_position;
            r_hin   <= w_hin;
            r_match <= w_match;
        end
    end

    // Execute-side decode
    assign w_cnt_x    = CMPW'(r_count);
    assign w_pos_x    = CMPW'(r_pos);
    assign w_cap_x    = CMPW'(r_cap);
    assign w_dep_x    = CMPW'(DEPTH);
    assign w_cap_eff  = (w_cap_x < w_dep_x) ? w_cap_x : w_dep_x;
    assign w_full     = (w_cnt_x >= w_cap_eff);
    assign w_in_range = (w_pos_x < w_cnt_x);
    assign w_idx      = IW'(r_pos);
    assign w_rd       = r_entry[w_idx];
    assign w_p        = (r_op == OP_APPEND) ? w_cnt_x : w_pos_x;
    // bits at and above the first match
    assign w_ge_val   = r_match | ~(r_match - DEPTH'(1));

    always_comb begin
        n_status  = ST_RANGE;
        n_hout    = '0;
        w_do_ins  = 1'b0;
        w_do_rem  = 1'b0;
        w_use_val = 1'b0;
        unique case (r_op)
            OP_INS_AT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else if (w_pos_x <= w_cnt_x) begin
                    n_status = ST_OK;
                    w_do_ins = 1'b1;
                end
            end
            OP_APPEND: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    w_do_ins = 1'b1;
                end
            end
            OP_REM_AT: begin
                if (w_in_range) begin
                    n_status = ST_OK;
                    n_hout   = HPORT_W'(w_rd);
                    w_do_rem = 1'b1;
                end
            end
            OP_REM_VAL: begin
                if (|r_match) begin
                    n_status  = ST_OK;
                    n_hout    = HPORT_W'(r_hin);
                    w_do_rem  = 1'b1;
                    w_use_val = 1'b1;
                end
            end
            OP_READ_AT: begin
                if (w_in_range) begin
                    n_status = ST_OK;
                    n_hout   = HPORT_W'(w_rd);
                end
            end
            OP_COUNT: n_status = ST_OK;
            default:  n_status = ST_RANGE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_do_ins)      n_count = r_count + CW'(1);
        else if (w_do_rem) n_count = r_count - CW'(1);
    end

    // Per-entry shift: insert moves entries up, remove closes the gap
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_ent
        logic [HANDLE_BITS-1:0] w_dn;
        logic [HANDLE_BITS-1:0] w_up;
        logic                   w_rm_ge;

        if (gi == 0) begin : g_first
            assign w_dn = r_hin;
        end else begin : g_mid_dn
            assign w_dn = r_entry[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_up = r_entry[gi];
        end else begin : g_mid_up
            assign w_up = r_entry[gi+1];
        end

        assign w_rm_ge = w_use_val ? w_ge_val[gi] : (CMPW'(gi) >= w_p);

        always_comb begin
            n_entry[gi] = r_entry[gi];
            if (w_do_ins) begin
                if (CMPW'(gi) == w_p)     n_entry[gi] = r_hin;
                else if (CMPW'(gi) > w_p) n_entry[gi] = w_dn;
            end else if (w_do_rem && w_rm_ge) begin
                n_entry[gi] = w_up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && (w_do_ins || w_do_rem)) begin
            r_entry <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (i_cmd.execute) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_hout    <= n_hout;
            r_cnt_out <= COUNT_W'(n_count);
            r_status  <= n_status;
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_handle_out    = r_hout;
    assign o_entry_count   = r_cnt_out;
    assign o_status        = r_status;

endmodule

### src/positional_list_engine_core.sv
// Positional list engine: ordered list of handles, insert/remove/read at index.
// Each request is latched with its compare results in idle, then applied
// in execute, which also loads the result register; a new request is taken
// only after that, and execute waits while the result register is held.
// Reset (synchronous, active low) empties the list, drops any pending result
// and sets the capacity limit to 16; entry contents are not cleared.
`timescale 1ns / 1ps

module positional_list_engine_core #(
    parameter int unsigned DEPTH       = 16,
    parameter int unsigned HANDLE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: capacity limit
    input  logic                           i_cfg_we,
    input  logic [plist_pkg::CAP_W-1:0]    i_cfg_data,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [plist_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [plist_pkg::POS_W-1:0]    i_position,
    input  logic [plist_pkg::HPORT_W-1:0]  i_handle_in,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [plist_pkg::HPORT_W-1:0]  o_handle_out,
    output logic [plist_pkg::COUNT_W-1:0]  o_entry_count,
    output logic [plist_pkg::STATUS_W-1:0] o_status
);
    import plist_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer: accept a beat in idle, then execute once the result slot is free
    plist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd)
    );

    // Datapath: compare on capture, shift and load the result on execute
    plist_dp #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_position    (i_position),
        .i_handle_in   (i_handle_in),
        .i_out_ready   (i_out_ready),
        .o_handle_out  (o_handle_out),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    // Hold the result beat until taken
    assign o_out_valid = w_sts.out_valid;

endmodule

### src/plist_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
// Depends on plist_pkg and positional_list_engine_core.
`timescale 1ns / 1ps

module plist_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [plist_pkg::CAP_W-1:0]    i_cfg_data,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic [plist_pkg::OPCODE_W-1:0] i_opcode,
    input logic [plist_pkg::POS_W-1:0]    i_position,
    input logic [plist_pkg::HPORT_W-1:0]  i_handle_in,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [plist_pkg::HPORT_W-1:0]  o_handle_out,
    input logic [plist_pkg::COUNT_W-1:0]  o_entry_count,
    input logic [plist_pkg::STATUS_W-1:0] o_status
);
    import plist_pkg::*;

    // one request in flight: no new beat the cycle after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in flight");

    // a result appears only while a request was executing
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result beat with no request executing");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_handle_out) && $stable(o_status)
             && $stable(o_entry_count)))
        else $error("result beat changed while stalled");

    // failed or full results carry no handle, and status is a known code
    a_fail_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == ST_OK) ||
                         ((o_status == ST_FULL || o_status == ST_RANGE)
                          && o_handle_out == '0)))
        else $error("bad status or handle on failed request");

endmodule

bind positional_list_engine_core plist_checker u_plist_checker (.*);
